### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ICX_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ICX_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

### rtl/icx_pkg.sv
// Shared types and constants of the indexed image to ARGB pixel core.
package icx_pkg;

   localparam int COLOR_TABLE_DEPTH_DEF   = 256;
   localparam int ALPHA_TABLE_DEPTH_DEF   = 256;
   localparam int VALUE_FRACTION_BITS_DEF = 16;

   localparam int VALUE_WIDTH = 32;
   localparam int LENGTH_WIDTH = 9;

   typedef enum logic [1:0] {
      ACT_PIXEL       = 2'd0,
      ACT_COLOR_WRITE = 2'd1,
      ACT_ALPHA_WRITE = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      CSR_COLOR_MODE      = 3'd0,
      CSR_COLOR_LIMIT_LO  = 3'd1,
      CSR_COLOR_LIMIT_HI  = 3'd2,
      CSR_COLOR_LENGTH    = 3'd3,
      CSR_ALPHA_MODE      = 3'd4,
      CSR_ALPHA_LIMIT_LO  = 3'd5,
      CSR_ALPHA_LIMIT_HI  = 3'd6,
      CSR_ALPHA_LENGTH    = 3'd7
   } csr_reg_type;

   localparam logic [2:0] COLOR_DIRECT_ONE  = 3'd0;
   localparam logic [2:0] COLOR_DIRECT_ZERO = 3'd1;
   localparam logic [2:0] COLOR_SCALED      = 3'd2;
   localparam logic [2:0] COLOR_TRUE_FRAC   = 3'd3;
   localparam logic [2:0] COLOR_TRUE_INT    = 3'd4;

   localparam logic [1:0] ALPHA_CLAMP  = 2'd0;
   localparam logic [1:0] ALPHA_DIRECT = 2'd1;
   localparam logic [1:0] ALPHA_SCALED = 2'd2;
   localparam logic [1:0] ALPHA_OPAQUE = 2'd3;

endpackage

### rtl/icx_ram.sv
// Generic simple dual-port RAM with registered read.
module icx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

endmodule

### rtl/icx_index_front.sv
// First stage of a table index path: limits, offset, direct index clamp.
module icx_index_front #(
   parameter int DEPTH = 256,
   parameter int IW    = 8,
   parameter int FRAC  = 16
) (
   input  logic          clock,
   input  logic          enable,
   input  logic [31:0]   value,
   input  logic [31:0]   limit_low,
   input  logic [31:0]   limit_high,
   input  logic [8:0]    length,
   input  logic          scaled,
   input  logic          one_based,
   output logic [32:0]   n_ff,
   output logic [32:0]   d_ff,
   output logic [IW-1:0] lm1_ff,
   output logic          use_q_ff,
   output logic [IW-1:0] fix_ix_ff
);

   localparam logic [31:0] FMASK = (32'(1) << FRAC) - 32'(1);

   logic signed [31:0] v_s, lo_s, hi_s, mn, mx;
   logic [IW:0]        clen;
   logic [IW-1:0]      lm1;
   logic [32:0]        d;
   logic [33:0]        diff, t;
   logic [31:0]        ip;
   logic               eq, neg, ge;
   logic [IW-1:0]      direct_ix;

   always_comb begin
      v_s  = $signed(value);
      lo_s = $signed(limit_low);
      hi_s = $signed(limit_high);
      mn   = (lo_s < hi_s) ? lo_s : hi_s;
      mx   = (lo_s < hi_s) ? hi_s : lo_s;
      clen = (32'(length) < DEPTH) ? (IW+1)'(length) : (IW+1)'(DEPTH);
      lm1  = IW'(clen - (IW+1)'(1));
      d    = {mx[31], mx} - {mn[31], mn};
      diff = {value[31], value[31], value} - {mn[31], mn[31], mn};
      eq   = (d == 33'd0);
      neg  = diff[33];
      ge   = (v_s >= mx);
      // integer part, truncated toward zero
      ip   = 32'(v_s >>> FRAC) + 32'(value[31] && ((value & FMASK) != 32'd0));
      t    = {ip[31], ip[31], ip} - 34'(one_based);
      if (t[33]) begin
         direct_ix = '0;
      end else if (t > 34'(lm1)) begin
         direct_ix = lm1;
      end else begin
         direct_ix = IW'(t);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         use_q_ff  <= scaled && !eq && !neg && !ge;
         n_ff      <= (scaled && !eq && !neg && !ge) ? diff[32:0] : 33'd0;
         d_ff      <= d;
         lm1_ff    <= lm1;
         if (scaled) begin
            fix_ix_ff <= (eq || neg) ? '0 : lm1;
         end else begin
            fix_ix_ff <= direct_ix;
         end
      end
   end

endmodule

### rtl/icx_scale_div.sv
// Pipelined scale and divide: one multiply stage, then one quotient bit per stage.
module icx_scale_div #(
   parameter int IW = 8,
   parameter int QW = 8
) (
   input  logic          clock,
   input  logic          enable,
   input  logic [32:0]   n,
   input  logic [32:0]   d,
   input  logic [IW-1:0] lm1,
   input  logic          use_q,
   input  logic [IW-1:0] fix_ix,
   output logic [IW-1:0] index
);

   localparam int RW = 33 + QW;

   logic [RW-1:0] rem_ff  [QW+1];
   logic [32:0]   d_ff    [QW+1];
   logic [QW-1:0] q_ff    [QW+1];
   logic          use_ff  [QW+1];
   logic [IW-1:0] fix_ff  [QW+1];

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= RW'(n) * RW'(lm1);
         d_ff[0]   <= d;
         q_ff[0]   <= '0;
         use_ff[0] <= use_q;
         fix_ff[0] <= fix_ix;
      end
   end

   for (genvar s = 1; s <= QW; s++) begin : g_step
      localparam int K = QW - s;
      logic [RW:0] dsh;
      logic        take;
      assign dsh  = (RW+1)'(d_ff[s-1]) << K;
      assign take = ({1'b0, rem_ff[s-1]} >= dsh);
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s] <= take ? RW'({1'b0, rem_ff[s-1]} - dsh) : rem_ff[s-1];
            q_ff[s]   <= q_ff[s-1] | (QW'(take) << K);
            d_ff[s]   <= d_ff[s-1];
            use_ff[s] <= use_ff[s-1];
            fix_ff[s] <= fix_ff[s-1];
         end
      end
   end

   // the quotient is below the table length here, so it fits the index
   assign index = use_ff[QW] ? IW'(q_ff[QW]) : fix_ff[QW];

endmodule

### rtl/indexed_image_to_argb_pixel_core.sv
// Top level of the indexed image to ARGB pixel core.
//
// Requests arrive on the req_ channel (valid/ready). A request with action
// pixel yields one ARGB result on the rsp_ channel; colormap and alpha map
// writes load the tables in stream order and give no result; action code 3
// is dropped at the input. Registers are written on the csr_ channel, which
// is always ready; the user must write them only while the core is idle, as
// the core itself does not enforce this. One request enters per clock while
// the receiver does not stall. A pixel result passes one front stage, one
// multiply stage and QW quotient-bit stages of the scaled-index divider (QW
// the log2 of the larger table depth), one table read and one output stage.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, every stage holds and req_ready drops, so nothing is lost
// or repeated. Synchronous reset clears the valid bits and the registers to
// their defaults; the tables are not cleared and must be written before use.
module indexed_image_to_argb_pixel_core #(
   parameter int COLOR_TABLE_DEPTH   = icx_pkg::COLOR_TABLE_DEPTH_DEF,
   parameter int ALPHA_TABLE_DEPTH   = icx_pkg::ALPHA_TABLE_DEPTH_DEF,
   parameter int VALUE_FRACTION_BITS = icx_pkg::VALUE_FRACTION_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_color_value,
   input  logic [31:0] req_green_value,
   input  logic [31:0] req_blue_value,
   input  logic [31:0] req_alpha_value,
   input  logic        req_end_of_image,
   input  logic [7:0]  req_table_slot,
   input  logic [7:0]  req_entry_red,
   input  logic [7:0]  req_entry_green,
   input  logic [7:0]  req_entry_blue,
   input  logic [7:0]  req_entry_alpha,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic        rsp_last_pixel,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

`include "assert_macros.svh"

   localparam int FRAC = VALUE_FRACTION_BITS;
   localparam int CIW  = $clog2(COLOR_TABLE_DEPTH);
   localparam int AIW  = $clog2(ALPHA_TABLE_DEPTH);
   localparam int QW   = (CIW > AIW) ? CIW : AIW;
   localparam int NS   = QW + 2;
   localparam int L    = NS - 1;
   localparam logic [40:0] FMASK41 = (41'(1) << FRAC) - 41'(1);
   localparam logic [31:0] ONE     = 32'(1) << FRAC;

   typedef struct packed {
      icx_pkg::action_type kind;
      logic [7:0]          slot;
      logic [23:0]         entry_rgb;
      logic [7:0]          entry_alpha;
      logic [23:0]         rgb;
      logic [7:0]          alpha;
      logic                color_tab;
      logic                alpha_tab;
      logic                last;
   } pipe_type;

   // configuration registers
   logic [2:0]  color_mode_ff;
   logic [31:0] color_lo_ff, color_hi_ff;
   logic [8:0]  color_len_ff;
   logic [1:0]  alpha_mode_ff;
   logic [31:0] alpha_lo_ff, alpha_hi_ff;
   logic [8:0]  alpha_len_ff;

   logic        advance;
   logic [NS-1:0] valid_ff;
   pipe_type    pipe_ff [NS];
   pipe_type    pipe_in;
   logic        valid_in;
   icx_pkg::action_type act;

   logic        mem_valid_ff;
   pipe_type    mem_ff;
   logic        rsp_valid_ff, rsp_last_ff;
   logic [7:0]  rsp_red_ff, rsp_green_ff, rsp_blue_ff, rsp_alpha_ff;

   logic [32:0]    c_n, c_d, a_n, a_d;
   logic [CIW-1:0] c_lm1, c_fix, c_index;
   logic [AIW-1:0] a_lm1, a_fix, a_index;
   logic           c_use_q, a_use_q;
   logic           c_we, c_re, a_we, a_re;
   logic [23:0]    c_rdata;
   logic [7:0]     a_rdata;
   logic [31:0]    a_clamped;
   logic [40:0]    a_prod;

   function automatic logic [7:0] frac_channel(logic [31:0] v);
      logic signed [40:0] p;
      logic signed [40:0] q;
      p = $signed({{9{v[31]}}, v}) * 41'sd255;
      q = p >>> FRAC;
      if (p[40] && ((p & FMASK41) != 41'd0)) begin
         q = q + 41'sd1;
      end
      return q[7:0];
   endfunction

   function automatic logic [7:0] int_channel(logic [31:0] v);
      logic signed [40:0] p;
      logic signed [40:0] q;
      p = $signed({{9{v[31]}}, v});
      q = p >>> FRAC;
      if (p[40] && ((p & FMASK41) != 41'd0)) begin
         q = q + 41'sd1;
      end
      return q[7:0];
   endfunction

   // hold everything while a result waits at the output
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff <= icx_pkg::COLOR_DIRECT_ONE;
         color_lo_ff   <= '0;
         color_hi_ff   <= ONE;
         color_len_ff  <= '0;
         alpha_mode_ff <= icx_pkg::ALPHA_CLAMP;
         alpha_lo_ff   <= '0;
         alpha_hi_ff   <= ONE;
         alpha_len_ff  <= '0;
      end else if (csr_valid) begin
         unique case (icx_pkg::csr_reg_type'(csr_index))
            icx_pkg::CSR_COLOR_MODE:     color_mode_ff <= csr_data[2:0];
            icx_pkg::CSR_COLOR_LIMIT_LO: color_lo_ff   <= csr_data;
            icx_pkg::CSR_COLOR_LIMIT_HI: color_hi_ff   <= csr_data;
            icx_pkg::CSR_COLOR_LENGTH:   color_len_ff  <= csr_data[8:0];
            icx_pkg::CSR_ALPHA_MODE:     alpha_mode_ff <= csr_data[1:0];
            icx_pkg::CSR_ALPHA_LIMIT_LO: alpha_lo_ff   <= csr_data;
            icx_pkg::CSR_ALPHA_LIMIT_HI: alpha_hi_ff   <= csr_data;
            icx_pkg::CSR_ALPHA_LENGTH:   alpha_len_ff  <= csr_data[8:0];
         endcase
      end
   end

   // front stage: true colour channels, alpha clamp, source selection
   always_comb begin
      act = icx_pkg::action_type'(req_action);
      valid_in = req_valid && (act == icx_pkg::ACT_PIXEL || act == icx_pkg::ACT_COLOR_WRITE
                               || act == icx_pkg::ACT_ALPHA_WRITE);
      pipe_in.kind        = act;
      pipe_in.slot        = req_table_slot;
      pipe_in.entry_rgb   = {req_entry_red, req_entry_green, req_entry_blue};
      pipe_in.entry_alpha = req_entry_alpha;
      pipe_in.last        = req_end_of_image;

      if (color_mode_ff == icx_pkg::COLOR_TRUE_FRAC) begin
         pipe_in.rgb = {frac_channel(req_color_value), frac_channel(req_green_value),
                        frac_channel(req_blue_value)};
         pipe_in.color_tab = 1'b0;
      end else if (color_mode_ff == icx_pkg::COLOR_TRUE_INT) begin
         pipe_in.rgb = {int_channel(req_color_value), int_channel(req_green_value),
                        int_channel(req_blue_value)};
         pipe_in.color_tab = 1'b0;
      end else begin
         // an empty colormap gives white
         pipe_in.rgb = 24'hFFFFFF;
         pipe_in.color_tab = (color_len_ff != 9'd0);
      end

      if (req_alpha_value[31]) begin
         a_clamped = '0;
      end else if (req_alpha_value > ONE) begin
         a_clamped = ONE;
      end else begin
         a_clamped = req_alpha_value;
      end
      a_prod = 41'(a_clamped) * 41'd255;
      if (alpha_mode_ff == icx_pkg::ALPHA_CLAMP) begin
         pipe_in.alpha     = 8'(a_prod >> FRAC);
         pipe_in.alpha_tab = 1'b0;
      end else begin
         pipe_in.alpha     = 8'hFF;
         pipe_in.alpha_tab = (alpha_mode_ff != icx_pkg::ALPHA_OPAQUE) && (alpha_len_ff != 9'd0);
      end
   end

   icx_index_front #(.DEPTH(COLOR_TABLE_DEPTH), .IW(CIW), .FRAC(FRAC)) u_color_front (
      .clock      (clock),
      .enable     (advance),
      .value      (req_color_value),
      .limit_low  (color_lo_ff),
      .limit_high (color_hi_ff),
      .length     (color_len_ff),
      .scaled     (color_mode_ff == icx_pkg::COLOR_SCALED),
      .one_based  (color_mode_ff != icx_pkg::COLOR_DIRECT_ZERO),
      .n_ff       (c_n),
      .d_ff       (c_d),
      .lm1_ff     (c_lm1),
      .use_q_ff   (c_use_q),
      .fix_ix_ff  (c_fix)
   );

   icx_index_front #(.DEPTH(ALPHA_TABLE_DEPTH), .IW(AIW), .FRAC(FRAC)) u_alpha_front (
      .clock      (clock),
      .enable     (advance),
      .value      (req_alpha_value),
      .limit_low  (alpha_lo_ff),
      .limit_high (alpha_hi_ff),
      .length     (alpha_len_ff),
      .scaled     (alpha_mode_ff == icx_pkg::ALPHA_SCALED),
      .one_based  (1'b1),
      .n_ff       (a_n),
      .d_ff       (a_d),
      .lm1_ff     (a_lm1),
      .use_q_ff   (a_use_q),
      .fix_ix_ff  (a_fix)
   );

   icx_scale_div #(.IW(CIW), .QW(QW)) u_color_div (
      .clock  (clock),
      .enable (advance),
      .n      (c_n),
      .d      (c_d),
      .lm1    (c_lm1),
      .use_q  (c_use_q),
      .fix_ix (c_fix),
      .index  (c_index)
   );

   icx_scale_div #(.IW(AIW), .QW(QW)) u_alpha_div (
      .clock  (clock),
      .enable (advance),
      .n      (a_n),
      .d      (a_d),
      .lm1    (a_lm1),
      .use_q  (a_use_q),
      .fix_ix (a_fix),
      .index  (a_index)
   );

   // payload delay line, aligned with the divider stages
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[NS-2:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff[0] <= pipe_in;
         for (int i = 1; i < NS; i++) begin
            pipe_ff[i] <= pipe_ff[i-1];
         end
      end
   end

   // table stage: writes and reads in stream order
   assign c_we = advance && valid_ff[L] && (pipe_ff[L].kind == icx_pkg::ACT_COLOR_WRITE)
                 && (32'(pipe_ff[L].slot) < COLOR_TABLE_DEPTH);
   assign a_we = advance && valid_ff[L] && (pipe_ff[L].kind == icx_pkg::ACT_ALPHA_WRITE)
                 && (32'(pipe_ff[L].slot) < ALPHA_TABLE_DEPTH);
   assign c_re = advance && valid_ff[L] && (pipe_ff[L].kind == icx_pkg::ACT_PIXEL);
   assign a_re = c_re;

   icx_ram #(.WIDTH(24), .DEPTH(COLOR_TABLE_DEPTH)) u_color_ram (
      .clock    (clock),
      .we       (c_we),
      .waddr    (CIW'(pipe_ff[L].slot)),
      .wdata    (pipe_ff[L].entry_rgb),
      .re       (c_re),
      .raddr    (c_index),
      .rdata_ff (c_rdata)
   );

   icx_ram #(.WIDTH(8), .DEPTH(ALPHA_TABLE_DEPTH)) u_alpha_ram (
      .clock    (clock),
      .we       (a_we),
      .waddr    (AIW'(pipe_ff[L].slot)),
      .wdata    (pipe_ff[L].entry_alpha),
      .re       (a_re),
      .raddr    (a_index),
      .rdata_ff (a_rdata)
   );

   // drop table writes here; only pixels go on
   always_ff @(posedge clock) begin
      if (reset) begin
         mem_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         mem_valid_ff <= c_re;
         rsp_valid_ff <= mem_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mem_ff       <= pipe_ff[L];
         rsp_red_ff   <= mem_ff.color_tab ? c_rdata[23:16] : mem_ff.rgb[23:16];
         rsp_green_ff <= mem_ff.color_tab ? c_rdata[15:8]  : mem_ff.rgb[15:8];
         rsp_blue_ff  <= mem_ff.color_tab ? c_rdata[7:0]   : mem_ff.rgb[7:0];
         rsp_alpha_ff <= mem_ff.alpha_tab ? a_rdata        : mem_ff.alpha;
         rsp_last_ff  <= mem_ff.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red        = rsp_red_ff;
   assign rsp_green      = rsp_green_ff;
   assign rsp_blue       = rsp_blue_ff;
   assign rsp_alpha      = rsp_alpha_ff;
   assign rsp_last_pixel = rsp_last_ff;

   `ICX_ASSERT(a_stall_holds_pipe, !advance |=> $stable(valid_ff) && $stable(mem_valid_ff),
               "pipeline moved during an output stall")
   `ICX_ASSERT(a_rsp_from_table_stage, $rose(rsp_valid_ff) |-> $past(mem_valid_ff),
               "result appeared without a pixel in the table stage")
   `ICX_ASSERT(a_table_port_exclusive, !(c_we && c_re) && !(a_we && a_re),
               "table read and write in the same cycle")

endmodule

### verif/argb_pixel_checker.sv
// Checker for the ARGB pixel core: predicts each pixel and compares responses.
`timescale 1ns / 1ps
module argb_pixel_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_color_value,
   input  logic [31:0] req_green_value,
   input  logic [31:0] req_blue_value,
   input  logic [31:0] req_alpha_value,
   input  logic        req_end_of_image,
   input  logic [7:0]  req_table_slot,
   input  logic [7:0]  req_entry_red,
   input  logic [7:0]  req_entry_green,
   input  logic [7:0]  req_entry_blue,
   input  logic [7:0]  req_entry_alpha,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_red,
   input  logic [7:0]  rsp_green,
   input  logic [7:0]  rsp_blue,
   input  logic [7:0]  rsp_alpha,
   input  logic        rsp_last_pixel,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          error_count,
   output int          pixels_pending
);

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       last;
   } argb_pixel_type;

   localparam int unsigned DEPTH = 256;

   argb_pixel_type expected_pixels[$];
   logic [23:0] color_map[DEPTH];
   logic [7:0]  alpha_map[DEPTH];

   logic [2:0]  color_mode;
   logic [31:0] color_lo, color_hi;
   logic [8:0]  color_len;
   logic [1:0]  alpha_mode;
   logic [31:0] alpha_lo, alpha_hi;
   logic [8:0]  alpha_len;

   function automatic int unsigned clamp_index(longint n, int unsigned len);
      if (n < 0) return 0;
      if (n > longint'(len) - 1) return len - 1;
      return int'(n);
   endfunction

   function automatic int unsigned scale_index(longint v, longint a, longint b,
                                               int unsigned len);
      longint lo, hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (hi == lo) return 0;
      return clamp_index(((v - lo) * longint'(len - 1)) / (hi - lo), len);
   endfunction

   function automatic logic [7:0] frac_channel(longint v);
      longint t;
      t = (v * 255) / 65536;
      return t[7:0];
   endfunction

   function automatic logic [7:0] int_channel(longint v);
      longint t;
      t = v / 65536;
      return t[7:0];
   endfunction

   function automatic argb_pixel_type predict_pixel(logic signed [31:0] cv_in,
                                                    logic signed [31:0] gv_in,
                                                    logic signed [31:0] bv_in,
                                                    logic signed [31:0] av_in,
                                                    logic eoi);
      argb_pixel_type px;
      longint cv, gv, bv, av, c;
      int unsigned clen, alen, ix;
      logic [23:0] entry;
      cv = cv_in;
      gv = gv_in;
      bv = bv_in;
      av = av_in;
      clen = (color_len > DEPTH) ? DEPTH : color_len;
      alen = (alpha_len > DEPTH) ? DEPTH : alpha_len;
      if (color_mode == icx_pkg::COLOR_TRUE_FRAC) begin
         px.red = frac_channel(cv);
         px.green = frac_channel(gv);
         px.blue = frac_channel(bv);
      end else if (color_mode == icx_pkg::COLOR_TRUE_INT) begin
         px.red = int_channel(cv);
         px.green = int_channel(gv);
         px.blue = int_channel(bv);
      end else if (clen == 0) begin
         px.red = 8'hFF;
         px.green = 8'hFF;
         px.blue = 8'hFF;
      end else begin
         if (color_mode == icx_pkg::COLOR_SCALED)
            ix = scale_index(cv, longint'($signed(color_lo)),
                             longint'($signed(color_hi)), clen);
         else if (color_mode == icx_pkg::COLOR_DIRECT_ZERO)
            ix = clamp_index(cv / 65536, clen);
         else
            ix = clamp_index(cv / 65536 - 1, clen);
         entry = color_map[ix];
         {px.red, px.green, px.blue} = entry;
      end
      if (alpha_mode == icx_pkg::ALPHA_CLAMP) begin
         c = (av < 0) ? 0 : ((av > 65536) ? 65536 : av);
         c = (c * 255) >>> 16;
         px.alpha = c[7:0];
      end else if (alpha_mode == icx_pkg::ALPHA_OPAQUE || alen == 0) begin
         px.alpha = 8'hFF;
      end else begin
         if (alpha_mode == icx_pkg::ALPHA_SCALED)
            ix = scale_index(av, longint'($signed(alpha_lo)),
                             longint'($signed(alpha_hi)), alen);
         else
            ix = clamp_index(av / 65536 - 1, alen);
         px.alpha = alpha_map[ix];
      end
      px.last = eoi;
      return px;
   endfunction

   initial error_count = 0;

   always @(posedge clock) begin
      argb_pixel_type want, got;
      if (reset) begin
         color_mode <= icx_pkg::COLOR_DIRECT_ONE;
         color_lo <= 32'd0;
         color_hi <= 32'h0001_0000;
         color_len <= 9'd0;
         alpha_mode <= icx_pkg::ALPHA_CLAMP;
         alpha_lo <= 32'd0;
         alpha_hi <= 32'h0001_0000;
         alpha_len <= 9'd0;
         expected_pixels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (icx_pkg::csr_reg_type'(csr_index))
               icx_pkg::CSR_COLOR_MODE:     color_mode <= csr_data[2:0];
               icx_pkg::CSR_COLOR_LIMIT_LO: color_lo <= csr_data;
               icx_pkg::CSR_COLOR_LIMIT_HI: color_hi <= csr_data;
               icx_pkg::CSR_COLOR_LENGTH:   color_len <= csr_data[8:0];
               icx_pkg::CSR_ALPHA_MODE:     alpha_mode <= csr_data[1:0];
               icx_pkg::CSR_ALPHA_LIMIT_LO: alpha_lo <= csr_data;
               icx_pkg::CSR_ALPHA_LIMIT_HI: alpha_hi <= csr_data;
               icx_pkg::CSR_ALPHA_LENGTH:   alpha_len <= csr_data[8:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_red, rsp_green, rsp_blue, rsp_alpha, rsp_last_pixel};
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected pixel %h", $time, got);
               error_count <= error_count + 1;
            end else begin
               want = expected_pixels.pop_front();
               if (want !== got) begin
                  $display("%0t: pixel mismatch exp r%h g%h b%h a%h l%b got r%h g%h b%h a%h l%b",
                           $time, want.red, want.green, want.blue, want.alpha, want.last,
                           got.red, got.green, got.blue, got.alpha, got.last);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            case (req_action)
               icx_pkg::ACT_COLOR_WRITE:
                  color_map[req_table_slot] <= {req_entry_red, req_entry_green, req_entry_blue};
               icx_pkg::ACT_ALPHA_WRITE:
                  alpha_map[req_table_slot] <= req_entry_alpha;
               icx_pkg::ACT_PIXEL:
                  expected_pixels.insert(expected_pixels.size(),
                                         predict_pixel(req_color_value, req_green_value,
                                                       req_blue_value, req_alpha_value,
                                                       req_end_of_image));
               default: ;
            endcase
         end
      end
      pixels_pending <= expected_pixels.size();
   end

endmodule

### verif/tb.sv
// Testbench top for the ARGB pixel core: stimulus, reset and verdict.
`timescale 1ns / 1ps
module tb;

   // Action code 3 is unused; the core must drop such requests.
   localparam logic [1:0] ACT_RESERVED = 2'd3;
   localparam int PHASES = 16;

   typedef struct {
      logic [1:0]  action;
      logic [31:0] cv, gv, bv, av;
      logic        eoi;
      logic [7:0]  slot, r, g, b, a;
   } request_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid, req_ready;
   logic [1:0]  req_action;
   logic [31:0] req_color_value, req_green_value, req_blue_value, req_alpha_value;
   logic        req_end_of_image;
   logic [7:0]  req_table_slot, req_entry_red, req_entry_green, req_entry_blue;
   logic [7:0]  req_entry_alpha;
   logic        rsp_valid, rsp_ready;
   logic [7:0]  rsp_red, rsp_green, rsp_blue, rsp_alpha;
   logic        rsp_last_pixel;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;
   int          error_count, pixels_pending;
   bit          quiet = 1'b0;

   indexed_image_to_argb_pixel_core u_dut (.*);

   argb_pixel_checker u_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hard stop in case the core hangs.
   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

   // Receiver stalls in random bursts; none once quiet is set.
   initial begin
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // Hold valid and payload until the request is taken; leave valid high.
   task automatic send_request(request_type rq);
      bit taken;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= rq.action;
      req_color_value <= rq.cv;
      req_green_value <= rq.gv;
      req_blue_value <= rq.bv;
      req_alpha_value <= rq.av;
      req_end_of_image <= rq.eoi;
      req_table_slot <= rq.slot;
      req_entry_red <= rq.r;
      req_entry_green <= rq.g;
      req_entry_blue <= rq.b;
      req_entry_alpha <= rq.a;
      // Inputs only move at the rising edge, so ready seen at the falling
      // edge is the ready of the next edge.
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic csr_write(icx_pkg::csr_reg_type idx, logic [31:0] data);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Drop valid and wait until every pixel is back, plus the pipe depth.
   task automatic drain();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      do @(negedge clock); while (pixels_pending != 0);
      @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value(logic [31:0] lo, logic [31:0] hi);
      longint a, b, span;
      a = $signed(lo);
      b = $signed(hi);
      if (a > b) begin
         span = a;
         a = b;
         b = span;
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return {16'($urandom_range(0, 265) - 5), 16'h0}
                            | $urandom_range(0, 65535);
         4, 5: begin
            span = b - a + 1;
            return 32'(a + longint'({$urandom, $urandom} % span));
         end
         6: return $urandom_range(0, 131072) - 32768;
         7: begin
            case ($urandom_range(0, 4))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0001_0000;
               3: return 32'hFFFF_FFFF;
               default: return 32'h0;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic request_type pixel_request(logic [31:0] cv, logic [31:0] av);
      request_type rq;
      rq.action = icx_pkg::ACT_PIXEL;
      rq.cv = cv;
      rq.gv = $urandom;
      rq.bv = $urandom;
      rq.av = av;
      rq.eoi = 1'($urandom_range(0, 1));
      rq.slot = 8'($urandom);
      rq.r = 8'($urandom);
      rq.g = 8'($urandom);
      rq.b = 8'($urandom);
      rq.a = 8'($urandom);
      return rq;
   endfunction

   function automatic logic [31:0] pick_limit(int sel);
      case (sel)
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return {16'($urandom_range(0, 300) - 20), 16'h0} | $urandom_range(0, 65535);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      request_type rq;
      logic [31:0] clo, chi, alo, ahi;
      int          nitems;
      int unsigned lengths[8] = '{0, 1, 2, 256, 511, 300, 257, 17};
      reset <= 1'b1;
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= icx_pkg::CSR_COLOR_MODE;
      csr_data <= 32'd0;
      rq = pixel_request(32'd0, 32'd0);
      req_action <= icx_pkg::ACT_PIXEL;
      req_color_value <= 32'd0;
      req_green_value <= 32'd0;
      req_blue_value <= 32'd0;
      req_alpha_value <= 32'd0;
      req_end_of_image <= 1'b0;
      req_table_slot <= 8'd0;
      req_entry_red <= 8'd0;
      req_entry_green <= 8'd0;
      req_entry_blue <= 8'd0;
      req_entry_alpha <= 8'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // At reset settings: empty colormap gives white, alpha clamps to unit.
      foreach (lengths[i]) begin
         rq = pixel_request(pick_value(32'h0, 32'h0001_0000),
                            (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF);
         send_request(rq);
      end
      rq = pixel_request(32'h0, 32'h0001_0000);
      send_request(rq);
      rq = pixel_request(32'h0, 32'h0000_8000);
      rq.action = ACT_RESERVED;
      send_request(rq);

      // Load both tables whole so that no unwritten entry is ever read.
      for (int s = 0; s < 256; s++) begin
         rq = pixel_request(32'h0, 32'h0);
         rq.action = icx_pkg::ACT_COLOR_WRITE;
         rq.slot = 8'(s);
         send_request(rq);
         rq.action = icx_pkg::ACT_ALPHA_WRITE;
         send_request(rq);
      end
      drain();

      for (int p = 0; p < PHASES; p++) begin
         quiet = (p >= PHASES - 2);
         case (p % 5)
            0: begin
               clo = pick_limit(2);
               chi = clo;
            end
            1: begin
               clo = pick_limit(2);
               chi = pick_limit(2);
               if ($signed(clo) < $signed(chi)) {clo, chi} = {chi, clo};
            end
            2: begin
               clo = pick_limit(0);
               chi = pick_limit(1);
            end
            3: begin
               clo = pick_limit(2);
               chi = pick_limit(2);
            end
            default: begin
               clo = pick_limit(3);
               chi = pick_limit(3);
            end
         endcase
         case ((p + 2) % 5)
            0: begin
               alo = pick_limit(2);
               ahi = alo;
            end
            1: begin
               alo = pick_limit(1);
               ahi = pick_limit(0);
            end
            2: begin
               alo = pick_limit(2);
               ahi = pick_limit(2);
            end
            default: begin
               alo = pick_limit(3);
               ahi = pick_limit(3);
            end
         endcase
         csr_write(icx_pkg::CSR_COLOR_MODE, p % 8);
         csr_write(icx_pkg::CSR_COLOR_LIMIT_LO, clo);
         csr_write(icx_pkg::CSR_COLOR_LIMIT_HI, chi);
         csr_write(icx_pkg::CSR_COLOR_LENGTH, lengths[p % 8]);
         csr_write(icx_pkg::CSR_ALPHA_MODE, p % 4);
         csr_write(icx_pkg::CSR_ALPHA_LIMIT_LO, alo);
         csr_write(icx_pkg::CSR_ALPHA_LIMIT_HI, ahi);
         csr_write(icx_pkg::CSR_ALPHA_LENGTH, lengths[(p + 3) % 8]);
         csr_valid <= 1'b0;

         // Counting only pixels and table writes; reserved actions are free.
         nitems = 0;
         while (nitems < 65) begin
            case ($urandom_range(0, 19))
               0, 1: begin
                  rq = pixel_request(32'h0, 32'h0);
                  rq.action = ($urandom_range(0, 1)) ? icx_pkg::ACT_COLOR_WRITE
                                                     : icx_pkg::ACT_ALPHA_WRITE;
                  nitems++;
               end
               2: begin
                  rq = pixel_request($urandom, $urandom);
                  rq.action = ACT_RESERVED;
               end
               default: begin
                  rq = pixel_request(pick_value(clo, chi), pick_value(alo, ahi));
                  nitems++;
               end
            endcase
            send_request(rq);
         end
         drain();
      end

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/icx_pkg.sv
rtl/icx_ram.sv
rtl/icx_index_front.sv
rtl/icx_scale_div.sv
rtl/indexed_image_to_argb_pixel_core.sv
verif/argb_pixel_checker.sv
verif/tb.sv
